// ===== hdl/nsa_pkg.sv =====
// Shared types and constants for the nearest sloped area search block.
// No dependencies; the top level, front end, back end and bench import this package.
package nsa_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 2'd1;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EMPTY = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // vector slots
  localparam logic [1:0] SLOT_CORNER_A = 2'd0;
  localparam logic [1:0] SLOT_CORNER_B = 2'd1;
  localparam logic [1:0] SLOT_CENTRE   = 2'd2;
  localparam logic [1:0] SLOT_NORMAL   = 2'd3;

  localparam logic [31:0] DIST_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         entry_index;
    logic [1:0]         vector_slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } nsa_in_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  area_index;
    logic [31:0] distance;
  } nsa_out_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_EMPTY,
    KIND_QUERY
  } nsa_kind_e;

  typedef struct packed {
    nsa_kind_e          kind;
    logic [9:0]         entry_index;
    logic [1:0]         vector_slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } nsa_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_RESULT
  } nsa_state_e;

  function automatic logic signed [31:0] clamp_box(input logic signed [31:0] v,
                                                   input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // difference saturated to +-(2^31 - 1)
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (d < -33'sh0_7FFF_FFFF) begin
      return -32'sh7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  // magnitude of a - b, always fits 32 bits
  function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [32:0] m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? -d : d;
    return m[31:0];
  endfunction

endpackage

// ===== hdl/nearest_sloped_area_search.sv =====
// Top level of the nearest sloped area search: config registers, front, back.
// Depends on nsa_pkg, nsa_front, nsa_back (and below it nsa_ram, nsa_div, nsa_sqrt).
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------
//  in      | in_valid_i / in_stall_o    | in_item_i   (nsa_in_t)
//  out     | out_valid_o / out_stall_i  | out_item_o  (nsa_out_t)
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Writes and empty marks are executed in the back end as they are popped. A query
// scans n = min(area_count, MAX_AREAS) entries: one table entry per cycle
// through the scan pipeline, whose depth is set by the 63-stage divider for
// the plane height, then the iterative square root if an area was found.
// After reset the back end sweeps the presence table, clearing every entry;
// items queue in the front (four deep) meanwhile, and cfg writes are taken.
// Output results sit in a register, so a stalled result does not block
// queued writes; only the next query's result waits for it.
module nearest_sloped_area_search #(
  parameter int unsigned MAX_AREAS = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  nsa_pkg::nsa_in_t                   in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output nsa_pkg::nsa_out_t                  out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nsa_pkg::CFG_DAT_W-1:0]      cfg_data_i
);
  import nsa_pkg::*;

  logic [10:0] area_count_q, area_count_d;
  logic [30:0] max_dist_q, max_dist_d;
  logic        cfg_wr;

  logic        cmd_valid, cmd_pop;
  nsa_cmd_t    cmd;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    area_count_d = area_count_q;
    max_dist_d   = max_dist_q;
    if (cfg_wr && cfg_index_i == REG_AREA_COUNT) begin
      area_count_d = cfg_data_i[10:0];
    end
    if (cfg_wr && cfg_index_i == REG_MAX_DIST) begin
      max_dist_d = cfg_data_i[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_count_q <= '0;
      max_dist_q   <= '0;
    end else begin
      area_count_q <= area_count_d;
      max_dist_q   <= max_dist_d;
    end
  end

  // front: classify and queue
  nsa_front #(.MAX_AREAS(MAX_AREAS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // back: tables, scan, result
  nsa_back #(.MAX_AREAS(MAX_AREAS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .area_count_i (area_count_q),
    .max_dist_i   (max_dist_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== hdl/nsa_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module nsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/nsa_front.sv =====
// Front end: accepts input items, drops ones with no effect, queues commands.
// Depends on nsa_pkg.
module nsa_front #(
  parameter int unsigned MAX_AREAS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nsa_pkg::nsa_in_t in_item_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output nsa_pkg::nsa_cmd_t cmd_o
);
  import nsa_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  nsa_cmd_t         fifo_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             accept, keep, push;
  logic             in_range;
  nsa_cmd_t         cmd;

  assign in_stall_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign accept      = in_valid_i && !in_stall_o;
  assign in_range    = (32'(in_item_i.entry_index) < 32'(MAX_AREAS));

  always_comb begin
    cmd.entry_index = in_item_i.entry_index;
    cmd.vector_slot = in_item_i.vector_slot;
    cmd.coord_x     = in_item_i.coord_x;
    cmd.coord_y     = in_item_i.coord_y;
    cmd.coord_z     = in_item_i.coord_z;
    cmd.kind        = KIND_QUERY;
    keep            = 1'b0;
    unique case (in_item_i.opcode)
      OP_WRITE: begin
        cmd.kind = KIND_WRITE;
        keep     = in_range;
      end
      OP_EMPTY: begin
        cmd.kind = KIND_EMPTY;
        keep     = in_range;
      end
      OP_QUERY: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push        = accept && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = cmd_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd;
    end
  end

endmodule

// ===== hdl/nsa_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with tag.
// No dependencies.
module nsa_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          v_q   [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] qd_q  [NW];
  logic [DW-1:0] den_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] qd_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign qd_in  = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign qd_in  = qd_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign trial = {rem_in, qd_in[NW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
      qd_q[s]  <= {qd_in[NW-2:0], ge};
      den_q[s] <= den_in;
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = qd_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

// ===== hdl/nsa_sqrt.sv =====
// Iterative 64-bit integer square root, two radicand bits per cycle.
// No dependencies.
module nsa_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d, r_q, r_d, b_q, b_d;
  logic [63:0] rb;

  assign rb = r_q + b_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      v_d    = value_i;
      r_d    = '0;
      b_d    = 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_d = v_q - rb;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d   = b_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

// ===== hdl/nsa_back.sv =====
// Back end: executes queued commands, area tables, scan pipeline, result reg.
// Depends on nsa_pkg, nsa_ram, nsa_div, nsa_sqrt.
module nsa_back #(
  parameter int unsigned MAX_AREAS = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [10:0]       area_count_i,
  input  logic [30:0]       max_dist_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  nsa_pkg::nsa_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nsa_pkg::nsa_out_t out_item_o
);
  import nsa_pkg::*;

  localparam int unsigned AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int unsigned CW = $clog2(MAX_AREAS + 1);
  localparam int unsigned FLAT_LIM = (1 << FRAC_BITS) / 10000;
  localparam logic signed [31:0] FLAT_POS = 32'(FLAT_LIM);
  localparam logic signed [31:0] FLAT_NEG = -FLAT_POS;
  localparam int unsigned TW = 1 + AW + 32 + 64 + 1;

  // ---------------- control ----------------
  nsa_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] scan_q, scan_d, n_q, n_d, infl_q, infl_d;
  logic          pop, issue, retire, sqrt_start;
  logic          out_load;
  logic          have_q, have_d;
  logic [63:0]   best_d_q, best_d_d;
  logic [AW-1:0] best_i_q, best_i_d;
  logic [31:0]   res_q, res_d;
  logic [63:0]   lim_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [CW-1:0] n_sel;
  logic          sqrt_done;
  logic [31:0]   sqrt_root;

  assign n_sel = (32'(area_count_i) > 32'(MAX_AREAS)) ? CW'(MAX_AREAS) : CW'(area_count_i);

  // ---------------- memories ----------------
  logic [AW-1:0] waddr, raddr;
  logic          flag_we, flag_wd, flag_rd;
  logic          vec_we [4];
  logic [95:0]   vec_rd [4];

  assign waddr = AW'(cmd_i.entry_index);
  assign raddr = scan_q[AW-1:0];

  always_comb begin
    flag_we = 1'b0;
    flag_wd = 1'b0;
    if (state_q == ST_CLEAR) begin
      flag_we = 1'b1;
    end else if (pop && cmd_i.kind == KIND_WRITE) begin
      flag_we = 1'b1;
      flag_wd = 1'b1;
    end else if (pop && cmd_i.kind == KIND_EMPTY) begin
      flag_we = 1'b1;
    end
  end

  nsa_ram #(.WIDTH(1), .DEPTH(MAX_AREAS)) u_flag (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i ((state_q == ST_CLEAR) ? clr_q : waddr),
    .wdata_i (flag_wd),
    .raddr_i (raddr),
    .rdata_o (flag_rd)
  );

  for (genvar k = 0; k < 4; k++) begin : g_vec
    assign vec_we[k] = pop && (cmd_i.kind == KIND_WRITE) && (cmd_i.vector_slot == 2'(k));
    nsa_ram #(.WIDTH(96), .DEPTH(MAX_AREAS)) u_vec (
      .clk_i   (clk_i),
      .we_i    (vec_we[k]),
      .waddr_i (waddr),
      .wdata_i ({cmd_i.coord_x, cmd_i.coord_y, cmd_i.coord_z}),
      .raddr_i (raddr),
      .rdata_o (vec_rd[k])
    );
  end

  // ---------------- scan pipeline ----------------
  logic          r_v_q;
  logic [AW-1:0] r_idx_q;

  logic          a_v_q, a_hit_q, a_flat_q;
  logic [AW-1:0] a_idx_q;
  logic signed [31:0] a_x_q, a_y_q, a_nx_q, a_ny_q, a_nz_q, a_cx_q, a_cy_q, a_cz_q;

  logic          b_v_q, b_hit_q, b_flat_q;
  logic [AW-1:0] b_idx_q;
  logic signed [31:0] b_dx_q, b_dy_q, b_nx_q, b_ny_q, b_nz_q, b_cz_q;
  logic [31:0]   b_ex_q, b_ey_q;

  logic          c_v_q, c_hit_q, c_flat_q;
  logic [AW-1:0] c_idx_q;
  logic signed [63:0] c_p1_q, c_p2_q;
  logic [63:0]   c_sqx_q, c_sqy_q;
  logic signed [31:0] c_nz_q, c_cz_q;

  logic          d_v_q, d_hit_q, d_flat_q;
  logic [AW-1:0] d_idx_q;
  logic signed [63:0] d_num_q;
  logic [63:0]   d_sxy_q;
  logic signed [31:0] d_nz_q, d_cz_q;

  logic          e_v_q;
  logic [62:0]   e_mag_q;
  logic [31:0]   e_den_q;
  logic [TW-1:0] e_tag_q;

  logic          q_v;
  logic [62:0]   q_mag;
  logic [TW-1:0] q_tag;
  logic          q_hit, q_neg;
  logic [AW-1:0] q_idx;
  logic signed [31:0] q_cz;
  logic [63:0]   q_sxy;

  logic          f_v_q, f_hit_q;
  logic [AW-1:0] f_idx_q;
  logic signed [63:0] f_qs_q;
  logic signed [31:0] f_cz_q;
  logic [63:0]   f_sxy_q;

  logic          g_v_q, g_hit_q;
  logic [AW-1:0] g_idx_q;
  logic signed [31:0] g_zc_q;
  logic [63:0]   g_sxy_q;

  logic          h_v_q, h_hit_q;
  logic [AW-1:0] h_idx_q;
  logic [31:0]   h_ez_q;
  logic [63:0]   h_sxy_q;

  logic          i_v_q, i_hit_q;
  logic [AW-1:0] i_idx_q;
  logic [63:0]   i_sqz_q, i_sxy_q;

  logic          j_v_q, j_hit_q;
  logic [AW-1:0] j_idx_q;
  logic [63:0]   j_tot_q;

  logic signed [31:0] ra_x, ra_y, rb_x, rb_y, rc_x, rc_y, rc_z, rn_x, rn_y, rn_z;
  logic [64:0]   sxy_w, tot_w;
  logic signed [63:0] num_w, num_abs;
  logic signed [31:0] nz_abs;
  logic signed [65:0] z_w;
  logic          in_radius, better;

  assign ra_x = vec_rd[SLOT_CORNER_A][95:64];
  assign ra_y = vec_rd[SLOT_CORNER_A][63:32];
  assign rb_x = vec_rd[SLOT_CORNER_B][95:64];
  assign rb_y = vec_rd[SLOT_CORNER_B][63:32];
  assign rc_x = vec_rd[SLOT_CENTRE][95:64];
  assign rc_y = vec_rd[SLOT_CENTRE][63:32];
  assign rc_z = vec_rd[SLOT_CENTRE][31:0];
  assign rn_x = vec_rd[SLOT_NORMAL][95:64];
  assign rn_y = vec_rd[SLOT_NORMAL][63:32];
  assign rn_z = vec_rd[SLOT_NORMAL][31:0];

  assign sxy_w   = {1'b0, c_sqx_q} + {1'b0, c_sqy_q};
  assign num_w   = d_flat_q ? 64'sd0 : d_num_q;
  assign num_abs = num_w[63] ? -num_w : num_w;
  assign nz_abs  = d_nz_q[31] ? -d_nz_q : d_nz_q;
  assign z_w     = {{34{f_cz_q[31]}}, f_cz_q} - {{2{f_qs_q[63]}}, f_qs_q};
  assign tot_w   = {1'b0, i_sxy_q} + {1'b0, i_sqz_q};

  assign {q_hit, q_idx, q_cz, q_sxy, q_neg} = q_tag;

  nsa_div #(.NW(63), .DW(32), .TW(TW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_v_q),
    .num_i   (e_mag_q),
    .den_i   (e_den_q),
    .tag_i   (e_tag_q),
    .valid_o (q_v),
    .quo_o   (q_mag),
    .tag_o   (q_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
    end else begin
      r_v_q <= issue;
      a_v_q <= r_v_q;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= q_v;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_idx_q  <= raddr;
    // clamp to the corner box, flat-normal test
    a_hit_q  <= flag_rd;
    a_idx_q  <= r_idx_q;
    a_x_q    <= clamp_box(px_q, ra_x, rb_x);
    a_y_q    <= clamp_box(py_q, ra_y, rb_y);
    a_flat_q <= (rn_z <= FLAT_POS) && (rn_z >= FLAT_NEG);
    a_nx_q   <= rn_x;
    a_ny_q   <= rn_y;
    a_nz_q   <= rn_z;
    a_cx_q   <= rc_x;
    a_cy_q   <= rc_y;
    a_cz_q   <= rc_z;
    // offsets from centre and from query point
    b_hit_q  <= a_hit_q;
    b_idx_q  <= a_idx_q;
    b_flat_q <= a_flat_q;
    b_dx_q   <= sat_diff(a_x_q, a_cx_q);
    b_dy_q   <= sat_diff(a_y_q, a_cy_q);
    b_ex_q   <= abs_diff(px_q, a_x_q);
    b_ey_q   <= abs_diff(py_q, a_y_q);
    b_nx_q   <= a_nx_q;
    b_ny_q   <= a_ny_q;
    b_nz_q   <= a_nz_q;
    b_cz_q   <= a_cz_q;
    // products
    c_hit_q  <= b_hit_q;
    c_idx_q  <= b_idx_q;
    c_flat_q <= b_flat_q;
    c_p1_q   <= 64'(b_nx_q) * 64'(b_dx_q);
    c_p2_q   <= 64'(b_ny_q) * 64'(b_dy_q);
    c_sqx_q  <= 64'(b_ex_q) * 64'(b_ex_q);
    c_sqy_q  <= 64'(b_ey_q) * 64'(b_ey_q);
    c_nz_q   <= b_nz_q;
    c_cz_q   <= b_cz_q;
    // plane numerator, xy distance part
    d_hit_q  <= c_hit_q;
    d_idx_q  <= c_idx_q;
    d_flat_q <= c_flat_q;
    d_num_q  <= c_p1_q + c_p2_q;
    d_sxy_q  <= sxy_w[64] ? '1 : sxy_w[63:0];
    d_nz_q   <= c_nz_q;
    d_cz_q   <= c_cz_q;
    // divider operands as magnitudes; flat normal divides zero by one
    e_mag_q  <= num_abs[62:0];
    e_den_q  <= d_flat_q ? 32'd1 : nz_abs;
    e_tag_q  <= {d_hit_q, d_idx_q, d_cz_q, d_sxy_q, (num_w[63] ^ d_nz_q[31])};
    // signed quotient
    f_hit_q  <= q_hit;
    f_idx_q  <= q_idx;
    f_qs_q   <= q_neg ? -{1'b0, q_mag} : {1'b0, q_mag};
    f_cz_q   <= q_cz;
    f_sxy_q  <= q_sxy;
    // plane height, clamped
    g_hit_q  <= f_hit_q;
    g_idx_q  <= f_idx_q;
    g_sxy_q  <= f_sxy_q;
    if (z_w > 66'sh0_7FFF_FFFF) begin
      g_zc_q <= 32'sh7FFF_FFFF;
    end else if (z_w < -66'sh0_8000_0000) begin
      g_zc_q <= 32'sh8000_0000;
    end else begin
      g_zc_q <= z_w[31:0];
    end
    h_hit_q  <= g_hit_q;
    h_idx_q  <= g_idx_q;
    h_sxy_q  <= g_sxy_q;
    h_ez_q   <= abs_diff(pz_q, g_zc_q);
    i_hit_q  <= h_hit_q;
    i_idx_q  <= h_idx_q;
    i_sxy_q  <= h_sxy_q;
    i_sqz_q  <= 64'(h_ez_q) * 64'(h_ez_q);
    j_hit_q  <= i_hit_q;
    j_idx_q  <= i_idx_q;
    j_tot_q  <= tot_w[64] ? '1 : tot_w[63:0];
  end

  // ---------------- candidate selection ----------------
  assign retire    = j_v_q;
  assign in_radius = (max_dist_i == '0) || (j_tot_q <= lim_q);
  assign better    = !have_q || (j_tot_q < best_d_q);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(MAX_AREAS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == KIND_QUERY) begin
          state_d = (n_sel == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q + 1'b1 == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (infl_q == '0) begin
          if (have_q) begin
            sqrt_start = 1'b1;
            state_d    = ST_ROOT;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == ST_RESULT) && (!out_valid_o || !out_stall_i);

  always_comb begin
    pop      = (state_q == ST_IDLE) && cmd_valid_i;
    issue    = (state_q == ST_SCAN);
    clr_d    = (state_q == ST_CLEAR) ? clr_q + 1'b1 : clr_q;
    scan_d   = issue ? scan_q + 1'b1 : scan_q;
    n_d      = n_q;
    infl_d   = infl_q + CW'(issue) - CW'(retire);
    have_d   = have_q;
    best_d_d = best_d_q;
    best_i_d = best_i_q;
    res_d    = res_q;
    if (pop && cmd_i.kind == KIND_QUERY) begin
      scan_d = '0;
      n_d    = n_sel;
      have_d = 1'b0;
    end
    if (retire && j_hit_q && in_radius && better) begin
      have_d   = 1'b1;
      best_d_d = j_tot_q;
      best_i_d = j_idx_q;
    end
    if (state_q == ST_DRAIN && infl_q == '0 && !have_q) begin
      res_d = DIST_NONE;
    end else if (state_q == ST_ROOT && sqrt_done) begin
      res_d = sqrt_root;
    end
  end

  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      scan_q  <= '0;
      n_q     <= '0;
      infl_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      n_q     <= n_d;
      infl_q  <= infl_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_d_q <= best_d_d;
    best_i_q <= best_i_d;
    res_q    <= res_d;
    lim_q    <= 64'(max_dist_i) * 64'(max_dist_i);
    if (pop && cmd_i.kind == KIND_QUERY) begin
      px_q <= cmd_i.coord_x;
      py_q <= cmd_i.coord_y;
      pz_q <= cmd_i.coord_z;
    end
  end

  nsa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (best_d_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // ---------------- result register ----------------
  logic     out_valid_q;
  nsa_out_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.found      <= have_q;
      out_item_q.area_index <= have_q ? 10'(best_i_q) : 10'd0;
      out_item_q.distance   <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/nearest_sloped_area_search_tb.sv =====
// Self-checking bench for nearest_sloped_area_search: directed table, then random
// write groups, empty marks and queries checked against an in-bench search model.
// Depends on nsa_pkg and the nearest_sloped_area_search RTL only.
module nearest_sloped_area_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsa_pkg::*;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam longint FLAT_NZ = (64'sd1 <<< 16) / 10000;   // 6 raw units in Q16.16
  localparam longint DIFF_MAX = 64'sd2147483647;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam int unsigned ITEM_TARGET = 570;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // one row of the directed table: a register write or an item,
  // optionally with a result read straight off the spec
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    nsa_in_t     item;
    bit          typed;
    nsa_out_t    result;
  } step_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  nsa_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i;
  nsa_out_t out_item_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  nearest_sloped_area_search i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Area table as the bench sees it
  // ---------------------------------------------------------------------------
  vec_t        corner_a_tbl [TABLE_SIZE];
  vec_t        corner_b_tbl [TABLE_SIZE];
  vec_t        centre_tbl   [TABLE_SIZE];
  vec_t        normal_tbl   [TABLE_SIZE];
  bit          present_tbl  [TABLE_SIZE];
  bit [3:0]    slots_loaded [TABLE_SIZE];   // a query may only see fully loaded entries
  logic [10:0] scan_count;
  logic [30:0] radius;

  nsa_out_t pending_results[$];
  int       error_count;
  int       items_sent;
  bit       calm_sender;
  step_t    steps[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
    error_count++;
    $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Search model
  // ---------------------------------------------------------------------------
  function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] square_mag(input longint d);
    logic [63:0] m;
    m = (d < 0) ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // squared distance from p to the sloped area in entry e, Q32, saturating
  function automatic logic [63:0] area_dist_sq(input int e, input longint px, input longint py,
                                               input longint pz);
    longint ax, bx, ay, by, qx, qy, qz, nz, num;
    logic [63:0] s;
    ax = corner_a_tbl[e].x;
    bx = corner_b_tbl[e].x;
    ay = corner_a_tbl[e].y;
    by = corner_b_tbl[e].y;
    qx = clamp_l(px, (ax < bx) ? ax : bx, (ax > bx) ? ax : bx);
    qy = clamp_l(py, (ay < by) ? ay : by, (ay > by) ? ay : by);
    nz = normal_tbl[e].z;
    if (nz <= FLAT_NZ && nz >= -FLAT_NZ) begin
      qz = centre_tbl[e].z;
    end else begin
      num = longint'(normal_tbl[e].x) * clamp_l(qx - centre_tbl[e].x, -DIFF_MAX, DIFF_MAX)
          + longint'(normal_tbl[e].y) * clamp_l(qy - centre_tbl[e].y, -DIFF_MAX, DIFF_MAX);
      qz = clamp_l(longint'(centre_tbl[e].z) - num / nz, -DIFF_MAX - 1, DIFF_MAX);
    end
    s = square_mag(px - qx);
    s = add_sat(s, square_mag(py - qy));
    return add_sat(s, square_mag(pz - qz));
  endfunction

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[31:0];
  endfunction

  function automatic nsa_out_t nearest_area(input nsa_in_t q);
    int unsigned n;
    logic [63:0] lim, d, best_d;
    bit have;
    int best_i;
    nsa_out_t r;
    n = (scan_count > TABLE_SIZE) ? TABLE_SIZE : scan_count;
    lim = 64'(radius) * 64'(radius);
    have = 1'b0;
    best_i = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      if (!present_tbl[i]) continue;
      d = area_dist_sq(i, q.coord_x, q.coord_y, q.coord_z);
      if (radius != 0 && d > lim) continue;
      // first hit always taken, later ones only when strictly closer
      if (!have || d < best_d) begin
        have = 1'b1;
        best_d = d;
        best_i = i;
      end
    end
    r.found = have;
    r.area_index = have ? 10'(best_i) : 10'd0;
    r.distance = have ? floor_root(best_d) : DIST_NONE;
    return r;
  endfunction

  function automatic void apply_item(input nsa_in_t it);
    vec_t v;
    v = '{it.coord_x, it.coord_y, it.coord_z};
    if (it.opcode == OP_WRITE) begin
      case (it.vector_slot)
        SLOT_CORNER_A: corner_a_tbl[it.entry_index] = v;
        SLOT_CORNER_B: corner_b_tbl[it.entry_index] = v;
        SLOT_CENTRE:   centre_tbl[it.entry_index] = v;
        default:       normal_tbl[it.entry_index] = v;
      endcase
      slots_loaded[it.entry_index][it.vector_slot] = 1'b1;
      present_tbl[it.entry_index] = 1'b1;
    end else if (it.opcode == OP_EMPTY) begin
      present_tbl[it.entry_index] = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm_sender) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // hold valid across back-to-back items; drop it only for a gap
  task automatic send_item(input nsa_in_t it, input bit typed, input nsa_out_t typed_res);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (it.opcode == OP_QUERY) begin
      pending_results = {pending_results, (typed ? typed_res : nearest_area(it))};
    end
    apply_item(it);
  endtask

  // pause the sender until every result is out and queued writes have retired
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    settle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_AREA_COUNT) scan_count = val[10:0];
    else if (idx == REG_MAX_DIST) radius = val[30:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // result side: stall in runs, some stretches with none at all
  int stall_run;
  initial begin
    out_stall_i = 1'b0;
    stall_run = 0;
    forever begin
      @(negedge clk_i);
      if (stall_run > 0) begin
        stall_run--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            out_stall_i = 1'b1;
            stall_run = $urandom_range(0, 3);
          end
          3: begin
            out_stall_i = 1'b1;
            stall_run = $urandom_range(20, 120);
          end
          4: begin
            out_stall_i = 1'b0;
            stall_run = $urandom_range(50, 300);
          end
          default: out_stall_i = 1'b0;
        endcase
      end
    end
  end

  // result checker, sampled on the rising edge
  always @(posedge clk_i) begin
    nsa_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'd0, 64'(out_item_o));
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.found !== want.found) report("found", want.found, out_item_o.found);
        if (out_item_o.area_index !== want.area_index)
          report("area_index", want.area_index, out_item_o.area_index);
        if (out_item_o.distance !== want.distance)
          report("distance", want.distance, out_item_o.distance);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic nsa_in_t mk(input logic [1:0] op, input int idx, input logic [1:0] slot,
                                 input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] z);
    nsa_in_t it;
    it.opcode = op;
    it.entry_index = 10'(idx);
    it.vector_slot = slot;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    return it;
  endfunction

  function automatic void add_item(input nsa_in_t it);
    step_t s;
    s = '{default: '0};
    s.item = it;
    steps = {steps, s};
  endfunction

  function automatic void add_typed(input nsa_in_t it, input bit f, input int idx,
                                    input logic [31:0] dist_v);
    step_t s;
    s = '{default: '0};
    s.item = it;
    s.typed = 1'b1;
    s.result = '{f, 10'(idx), dist_v};
    steps = {steps, s};
  endfunction

  function automatic void add_reg(input logic [1:0] idx, input logic [31:0] val);
    step_t s;
    s = '{default: '0};
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    steps = {steps, s};
  endfunction

  function automatic void add_area(input int e, input vec_t a, input vec_t b, input vec_t c,
                                   input vec_t nrm);
    add_item(mk(OP_WRITE, e, SLOT_CORNER_A, a.x, a.y, a.z));
    add_item(mk(OP_WRITE, e, SLOT_CORNER_B, b.x, b.y, b.z));
    add_item(mk(OP_WRITE, e, SLOT_CENTRE, c.x, c.y, c.z));
    add_item(mk(OP_WRITE, e, SLOT_NORMAL, nrm.x, nrm.y, nrm.z));
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          2: return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return $urandom;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_nz();
    if ($urandom_range(0, 9) < 3) return 32'($urandom_range(0, 12)) - 32'd6;   // flat band
    return rand_coord();
  endfunction

  function automatic int rand_entry();
    if ($urandom_range(0, 9) == 0) return $urandom_range(TABLE_SIZE - 48, TABLE_SIZE - 1);
    return $urandom_range(0, 47);
  endfunction

  task automatic random_registers();
    case ($urandom_range(0, 9))
      0: write_reg(REG_AREA_COUNT, 32'd0);
      1: write_reg(REG_AREA_COUNT, 32'(TABLE_SIZE));
      2: write_reg(REG_AREA_COUNT, 32'($urandom_range(TABLE_SIZE + 1, 2047)));
      default: write_reg(REG_AREA_COUNT, 32'($urandom_range(1, 48)));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: write_reg(REG_MAX_DIST, 32'd0);
      4, 5: write_reg(REG_MAX_DIST, 32'($urandom_range(1, 32'h7FFF_FFFF)));
      6, 7, 8: write_reg(REG_MAX_DIST, 32'($urandom_range(1, 32'h0040_0000)));
      default: write_reg(REG_MAX_DIST, 32'h7FFF_FFFF);
    endcase
  endtask

  // a fresh entry gets all four slots back to back, in a random rotation,
  // so no query ever sees a half-loaded entry
  task automatic random_write();
    int e, start, dir;
    logic [1:0] slot;
    nsa_out_t none;
    none = '0;
    e = rand_entry();
    if (slots_loaded[e] == 4'hF && $urandom_range(0, 1)) begin
      slot = 2'($urandom_range(0, 3));
      send_item(mk(OP_WRITE, e, slot, rand_coord(), rand_coord(),
                   (slot == SLOT_NORMAL) ? rand_nz() : rand_coord()), 1'b0, none);
    end else begin
      start = $urandom_range(0, 3);
      dir = $urandom_range(0, 1) ? 1 : 3;
      for (int k = 0; k < 4; k++) begin
        slot = 2'(start + k * dir);
        send_item(mk(OP_WRITE, e, slot, rand_coord(), rand_coord(),
                     (slot == SLOT_NORMAL) ? rand_nz() : rand_coord()), 1'b0, none);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    nsa_out_t none;
    int pick;
    none = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    error_count = 0;
    items_sent = 0;
    calm_sender = 1'b0;
    scan_count = '0;
    radius = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      corner_a_tbl[i] = '0;
      corner_b_tbl[i] = '0;
      centre_tbl[i] = '0;
      normal_tbl[i] = '0;
      present_tbl[i] = 1'b0;
      slots_loaded[i] = '0;
    end

    // directed table
    add_typed(mk(OP_QUERY, 0, 0, 0, 0, 0), 1'b0, 0, DIST_NONE);          // count 0 after reset
    add_area(0, '{-ONE, -ONE, 0}, '{ONE, ONE, 0}, '{0, 0, 0}, '{0, 0, ONE});
    add_reg(REG_AREA_COUNT, 32'd2047);                                   // beyond the table
    add_typed(mk(OP_QUERY, 0, 0, 0, 0, 3 * ONE), 1'b1, 0, 3 * ONE);
    add_item(mk(OP_EMPTY, 0, 0, 0, 0, 0));
    // two identical far boxes: squared distance saturates, first one wins
    add_area(5, '{S_MAX, S_MAX, 0}, '{S_MAX, S_MAX, 0}, '{0, 0, S_MAX}, '{0, 0, -6});
    add_area(6, '{S_MAX, S_MAX, 0}, '{S_MAX, S_MAX, 0}, '{0, 0, S_MAX}, '{0, 0, -6});
    add_typed(mk(OP_QUERY, 0, 0, S_MIN, S_MIN, S_MIN), 1'b1, 5, DIST_NONE);
    add_item(mk(OP_UNUSED, 1023, 3, S_MAX, S_MAX, S_MAX));                // ignored opcode
    // whole-range box with a steep plane, saturating the slope terms
    add_area(1023, '{S_MIN, S_MIN, S_MIN}, '{S_MAX, S_MAX, S_MAX}, '{0, 0, 0},
             '{S_MAX, S_MIN, -7});
    add_item(mk(OP_QUERY, 0, 0, S_MAX, S_MAX, S_MAX));
    add_reg(REG_MAX_DIST, 32'd1);
    add_item(mk(OP_QUERY, 0, 0, 0, 0, 0));
    add_reg(REG_MAX_DIST, 32'h7FFF_FFFF);
    add_item(mk(OP_QUERY, 0, 0, S_MAX, 0, S_MIN));
    add_item(mk(OP_EMPTY, 5, 0, 0, 0, 0));
    add_item(mk(OP_WRITE, 0, SLOT_CENTRE, 0, 0, ONE));                  // re-marks entry 0 present
    add_item(mk(OP_QUERY, 0, 0, ONE, 2 * ONE, 3 * ONE));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (steps[i]) begin
      if (steps[i].is_reg) write_reg(steps[i].reg_idx, steps[i].reg_val);
      else send_item(steps[i].item, steps[i].typed, steps[i].result);
    end

    // random phases, each behind a fresh register setting
    while (items_sent < ITEM_TARGET) begin
      random_registers();
      for (int k = 0; k < 40 && items_sent < ITEM_TARGET; k++) begin
        if ($urandom_range(0, 15) == 0) calm_sender = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          random_write();
        end else if (pick < 10) begin
          send_item(mk(OP_EMPTY, rand_entry(), 2'($urandom), $urandom, $urandom, $urandom),
                    1'b0, none);
        end else if (pick < 11) begin
          send_item(mk(OP_UNUSED, $urandom_range(0, 1023), 2'($urandom), $urandom, $urandom,
                       $urandom), 1'b0, none);
        end else begin
          send_item(mk(OP_QUERY, $urandom_range(0, 1023), 2'($urandom), rand_coord(),
                       rand_coord(), rand_coord()), 1'b0, none);
        end
      end
    end

    settle();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
